>>> sv/lrukv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared types and constants of the lru key-value cache.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_GET  = 2'd1;
  localparam logic [1:0] CMD_LIST = 2'd2;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_GET,
    OP_LIST,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } item_t;

endpackage
`default_nettype wire

>>> sv/lrukv_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrukv_front
// Accepts command words, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lrukv_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   command,
  input  wire logic [lrukv_pkg::DATA_W-1:0] key,
  input  wire logic [lrukv_pkg::DATA_W-1:0] value,
  output logic                              q_valid,
  output lrukv_pkg::item_t                  q_item,
  input  wire logic                         q_pop
);

  lrukv_pkg::item_t in_item;
  lrukv_pkg::item_t slot0;
  lrukv_pkg::item_t slot1;
  logic [1:0]       count;
  logic             push;

  always_comb begin
    unique case (command)
      lrukv_pkg::CMD_PUT:  in_item.op = lrukv_pkg::OP_PUT;
      lrukv_pkg::CMD_GET:  in_item.op = lrukv_pkg::OP_GET;
      lrukv_pkg::CMD_LIST: in_item.op = lrukv_pkg::OP_LIST;
      default:             in_item.op = lrukv_pkg::OP_BAD;
    endcase
    in_item.key   = key;
    in_item.value = value;
  end

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_item  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, q_pop})
        2'b10: begin
          if (count == 2'd0) slot0 <= in_item;
          else               slot1 <= in_item;
          count <= count + 2'd1;
        end
        2'b01: begin
          slot0 <= slot1;
          count <= count - 2'd1;
        end
        2'b11: begin
          // one word leaves while another arrives
          if (count == 2'd1) begin
            slot0 <= in_item;
          end else begin
            slot0 <= slot1;
            slot1 <= in_item;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/lrukv_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrukv_back
// Executes queued words: key match, lru choice, rank update and key listing.
// ----------------------------------------------------------------------------
module lrukv_back #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                q_valid,
  input  wire lrukv_pkg::item_t                    q_item,
  output logic                                     q_pop,
  input  wire logic [$clog2(MAX_ENTRIES+1)-1:0]    eff_cap,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]         fill_count,
  output logic                                     result_strobe,
  output logic                                     hit,
  output logic [lrukv_pkg::DATA_W-1:0]             key_out,
  output logic [lrukv_pkg::DATA_W-1:0]             value_out,
  output logic                                     last
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST,
    S_DRAIN
  } state_t;

  state_t state;

  logic [lrukv_pkg::DATA_W-1:0] entry_key [MAX_ENTRIES];
  logic [IW-1:0]                rank      [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]       valid;

  logic [lrukv_pkg::DATA_W-1:0] key_mem [MAX_ENTRIES];
  logic [lrukv_pkg::DATA_W-1:0] val_mem [MAX_ENTRIES];
  logic [lrukv_pkg::DATA_W-1:0] key_rdata;
  logic [lrukv_pkg::DATA_W-1:0] val_rdata;

  // executing word
  lrukv_pkg::op_t               op_q;
  logic [lrukv_pkg::DATA_W-1:0] key_q;
  logic [lrukv_pkg::DATA_W-1:0] value_q;
  logic                         hit_q;
  logic                         new_q;
  logic [IW-1:0]                slot_q;
  logic [IW-1:0]                list_rank;
  logic                         pend_last;

  logic [MAX_ENTRIES-1:0] match;
  logic [IW-1:0]          match_idx;
  logic [IW-1:0]          free_idx;
  logic [IW-1:0]          lru_idx;
  logic [IW-1:0]          list_idx;
  logic                   match_any;
  logic                   full;
  logic [CW-1:0]          old_rank;
  logic [CW-1:0]          fill_last;
  logic                   do_promote;
  logic                   do_write;

  assign fill_last = fill_count - CW'(1);
  assign full      = (fill_count >= eff_cap);
  assign q_pop     = (state == S_IDLE) && q_valid;

  // parallel key compare and slot encoders
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    lru_idx   = '0;
    list_idx  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = valid[i] && (entry_key[i] == q_item.key);
      if (match[i]) match_idx = match_idx | IW'(i);
      if (valid[i] && (CW'(rank[i]) == fill_last)) lru_idx = lru_idx | IW'(i);
      if (valid[i] && (rank[i] == list_rank)) list_idx = list_idx | IW'(i);
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) free_idx = IW'(i);
    end
    match_any = |match;
  end

  assign old_rank   = new_q ? fill_count : CW'(rank[slot_q]);
  assign do_promote = (state == S_EXEC) &&
                      ((op_q == lrukv_pkg::OP_PUT) || (hit_q && (op_q == lrukv_pkg::OP_GET)));
  assign do_write   = (state == S_EXEC) && (op_q == lrukv_pkg::OP_PUT);

  // entry state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      fill_count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) rank[i] <= '0;
    end else begin
      if (do_promote) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (valid[i] && (IW'(i) != slot_q) && (CW'(rank[i]) < old_rank)) begin
            rank[i] <= rank[i] + IW'(1);
          end
        end
        rank[slot_q] <= '0;
      end
      if (do_write && new_q) begin
        valid[slot_q] <= 1'b1;
        fill_count    <= fill_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) entry_key[slot_q] <= key_q;
  end

  // key copy for listing and value store
  always_ff @(posedge clk) begin
    if (do_write) key_mem[slot_q] <= key_q;
    key_rdata <= key_mem[list_idx];
  end

  always_ff @(posedge clk) begin
    if (do_write) val_mem[slot_q] <= value_q;
    val_rdata <= val_mem[match_idx];
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            op_q    <= q_item.op;
            key_q   <= q_item.key;
            value_q <= q_item.value;
            hit_q   <= match_any;
            new_q   <= !match_any && !full;
            if (match_any)  slot_q <= match_idx;
            else if (!full) slot_q <= free_idx;
            else            slot_q <= lru_idx;
            unique case (q_item.op)
              lrukv_pkg::OP_PUT, lrukv_pkg::OP_GET: begin
                state <= S_EXEC;
              end
              lrukv_pkg::OP_LIST: begin
                if (fill_count == '0) begin
                  result_strobe <= 1'b1;
                  hit           <= 1'b0;
                  key_out       <= '0;
                  value_out     <= '0;
                  last          <= 1'b1;
                end else begin
                  list_rank <= '0;
                  state     <= S_LIST;
                end
              end
              default: begin
                result_strobe <= 1'b1;
                hit           <= 1'b0;
                key_out       <= q_item.key;
                value_out     <= '0;
                last          <= 1'b1;
              end
            endcase
          end
        end
        S_EXEC: begin
          result_strobe <= 1'b1;
          hit           <= hit_q;
          key_out       <= key_q;
          last          <= 1'b1;
          if (op_q == lrukv_pkg::OP_GET) value_out <= hit_q ? val_rdata : lrukv_pkg::MISS_VALUE;
          else                           value_out <= '0;
          state <= S_IDLE;
        end
        S_LIST: begin
          // key read for the previous rank is out of the copy store now
          if (list_rank != '0) begin
            result_strobe <= 1'b1;
            hit           <= 1'b1;
            key_out       <= key_rdata;
            value_out     <= '0;
            last          <= 1'b0;
          end
          pend_last <= (CW'(list_rank) == fill_last);
          if (CW'(list_rank) == fill_last) state <= S_DRAIN;
          else                             list_rank <= list_rank + IW'(1);
        end
        S_DRAIN: begin
          result_strobe <= 1'b1;
          hit           <= 1'b1;
          key_out       <= key_rdata;
          value_out     <= '0;
          last          <= pend_last;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/lru_key_value_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A command word (command, key, value) is taken at a clock edge with start
// high and busy low; it lands in a two-word queue, so busy rises only when
// both queue slots are taken. The execution side pops one word at a time.
// Put and get: one result per word, through two steps: the parallel key
// compare and slot choice, then the rank update and the value store
// access; the execution side pops no new word until both are done.
// List: one key per cycle from most to least recent, last set on the final
// key; an empty cache gives one result with hit clear.
// Each result is shown for one cycle with result_strobe high; the receiver
// cannot stall, so results never back up.
// cfg_we/cfg_data write the capacity; the write is dropped while any entry
// is valid. Reset clears valid bits, ranks, the fill count and the queue and
// sets the capacity to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          command,
  input  wire logic signed [lrukv_pkg::DATA_W-1:0] key,
  input  wire logic signed [lrukv_pkg::DATA_W-1:0] value,
  input  wire logic                                cfg_we,
  input  wire logic [lrukv_pkg::CAP_W-1:0]         cfg_data,
  output logic                                     result_strobe,
  output logic                                     hit,
  output logic signed [lrukv_pkg::DATA_W-1:0]      key_out,
  output logic signed [lrukv_pkg::DATA_W-1:0]      value_out,
  output logic                                     last
);

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > lrukv_pkg::CAP_W) ? CW : lrukv_pkg::CAP_W;

  logic [lrukv_pkg::CAP_W-1:0] cache_capacity;
  logic [CW-1:0]               fill_count;
  logic [CW-1:0]               eff_cap;
  logic [CMPW-1:0]             cap_ext;
  logic                        q_valid;
  logic                        q_pop;
  lrukv_pkg::item_t            q_item;
  logic [lrukv_pkg::DATA_W-1:0] key_out_u;
  logic [lrukv_pkg::DATA_W-1:0] value_out_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_capacity <= lrukv_pkg::CAP_RESET;
    end else if (cfg_we && (fill_count == '0)) begin
      cache_capacity <= cfg_data;
    end
  end

  // clamp the capacity into 1..MAX_ENTRIES
  assign cap_ext = CMPW'(cache_capacity);
  always_comb begin
    priority if (cap_ext == '0)                 eff_cap = CW'(1);
    else if (cap_ext > CMPW'(MAX_ENTRIES))      eff_cap = CW'(MAX_ENTRIES);
    else                                        eff_cap = cap_ext[CW-1:0];
  end

  lrukv_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .command (command),
    .key     (key),
    .value   (value),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  lrukv_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .eff_cap       (eff_cap),
    .fill_count    (fill_count),
    .result_strobe (result_strobe),
    .hit           (hit),
    .key_out       (key_out_u),
    .value_out     (value_out_u),
    .last          (last)
  );

  assign key_out   = key_out_u;
  assign value_out = value_out_u;

endmodule
`default_nettype wire
